[rtl/tfs_pkg.sv]
package tfs_pkg;

  localparam int MaxSize = 16;
  localparam int IdxW    = 4;
  localparam int CoefAw  = 8;

  typedef enum logic [1:0] {
    CMD_COEF  = 2'd0,
    CMD_RHS   = 2'd1,
    CMD_SOLVE = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ZERO = 2'd1,
    ST_SAT  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_MAC,
    S_DIVINIT,
    S_DIV,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [IdxW-1:0]   row;
    logic [IdxW-1:0]   col;
    logic signed [31:0] value;
  } in_t;

  typedef struct packed {
    logic [IdxW-1:0]    unknown_index;
    logic signed [31:0] solution;
    logic [1:0]         status;
    logic               last;
  } out_t;

  // controller -> datapath
  typedef struct packed {
    logic            row_clr;   // start a new unknown
    logic            mac;       // accumulate product of registered reads
    logic            div_init;  // load divider
    logic            div_step;  // one restoring step
    logic            emit;      // finalize and store x[i]
    logic [IdxW-1:0] i;
    logic [IdxW-1:0] j;
  } ctl_t;

endpackage

[rtl/triangular_forward_substitution_unit.sv]
// Load items (coefficient, right-hand side) are accepted one per cycle while busy is low.
// A solve runs per unknown i: reads and multiply-accumulate over j = 0..i,
// the bit-serial divider, then an emit of x[i]; busy stays high.
// The divider dominates a solve; no new item is accepted until the solve ends.
// Reset: asynchronous active low; size 1, solutions zero, stores undefined.
module triangular_forward_substitution_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  tfs_pkg::in_t   in_i,
  input  logic           cfg_we_i,
  input  logic [4:0]     cfg_data_i,
  output logic           strobe,
  output tfs_pkg::out_t  out_o
);
  import tfs_pkg::*;

  logic [4:0] size_q;
  ctl_t       ctl;
  logic       last, accept;

  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) size_q <= 5'd1;
    else if (cfg_we_i) size_q <= cfg_data_i;
  end

  tfs_ctrl u_ctrl (
    .clk_i, .rst_ni, .solve_i(accept && in_i.cmd == CMD_SOLVE), .size_i(size_q),
    .ctl_o(ctl), .last_o(last), .busy_o(busy), .valid_o(strobe)
  );

  tfs_datapath u_dp (
    .clk_i, .rst_ni, .load_i(in_i), .load_we_i(accept), .ctl_i(ctl),
    .last_i(last), .res_o(out_o)
  );

  a_strobe_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe |-> busy) else $error("result outside solve");
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe && out_o.last |=> !busy) else $error("busy after last");
  a_first_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_i.cmd == CMD_SOLVE |=> ctl.i == '0) else $error("bad start index");
endmodule

[rtl/tfs_ram.sv]
module tfs_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

[rtl/tfs_datapath.sv]
module tfs_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tfs_pkg::in_t        load_i,
  input  logic                load_we_i,
  input  tfs_pkg::ctl_t       ctl_i,
  input  logic                last_i,
  output tfs_pkg::out_t       res_o
);
  import tfs_pkg::*;

  logic               coef_we, rhs_we;
  logic [CoefAw-1:0]  coef_raddr;
  logic [31:0]        coef_rd, rhs_rd;
  logic signed [31:0] x_q [MaxSize];
  logic signed [31:0] xj_q;
  logic signed [63:0] acc_q;
  logic [63:0]        num;
  logic [63:0]        rem_q, quo_q;
  logic [31:0]        dmag_q;
  logic               neg_q, zero_q;
  logic signed [63:0] prod;
  logic [64:0]        trial;
  logic [63:0]        shifted;

  assign coef_we = load_we_i && (load_i.cmd == CMD_COEF) && (load_i.col <= load_i.row);
  assign rhs_we  = load_we_i && (load_i.cmd == CMD_RHS);

  // read a[i][j] during MAC, a[i][i] when j reaches i
  assign coef_raddr = {ctl_i.i, ctl_i.j};

  tfs_ram #(.Width(32), .Depth(MaxSize*MaxSize)) u_coef (
    .clk_i, .we_i(coef_we), .waddr_i({load_i.row, load_i.col}),
    .wdata_i(load_i.value), .raddr_i(coef_raddr), .rdata_o(coef_rd)
  );

  tfs_ram #(.Width(32), .Depth(MaxSize)) u_rhs (
    .clk_i, .we_i(rhs_we), .waddr_i(load_i.row),
    .wdata_i(load_i.value), .raddr_i(ctl_i.i), .rdata_o(rhs_rd)
  );

  assign prod    = xj_q * $signed(coef_rd);
  assign num     = 64'($signed(rhs_rd)) - acc_q;
  assign shifted = {rem_q[62:0], quo_q[63]};
  assign trial   = {1'b0, shifted} - {33'd0, dmag_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MaxSize; k++) x_q[k] <= '0;
    end else if (ctl_i.emit) begin
      x_q[ctl_i.i] <= res_o.solution;
    end
  end

  always_ff @(posedge clk_i) begin
    xj_q <= x_q[ctl_i.j];
    if (ctl_i.row_clr) acc_q <= '0;
    else if (ctl_i.mac) acc_q <= acc_q + prod;
    if (ctl_i.div_init) begin
      zero_q <= (coef_rd == '0);
      dmag_q <= coef_rd[31] ? 32'(-coef_rd) : coef_rd;
      neg_q  <= num[63] ^ coef_rd[31];
      quo_q  <= num[63] ? -num : num;
      rem_q  <= '0;
    end else if (ctl_i.div_step) begin
      if (!trial[64]) begin
        rem_q <= trial[63:0];
        quo_q <= {quo_q[62:0], 1'b1};
      end else begin
        rem_q <= shifted;
        quo_q <= {quo_q[62:0], 1'b0};
      end
    end
  end

  always_comb begin
    res_o.unknown_index = ctl_i.i;
    res_o.last          = last_i;
    res_o.status        = ST_OK;
    if (zero_q) begin
      res_o.solution = '0;
      res_o.status   = ST_ZERO;
    end else if (!neg_q) begin
      if (quo_q > 64'h7FFF_FFFF) begin
        res_o.solution = 32'h7FFF_FFFF;
        res_o.status   = ST_SAT;
      end else begin
        res_o.solution = quo_q[31:0];
      end
    end else begin
      if (quo_q > 64'h8000_0000) begin
        res_o.solution = 32'h8000_0000;
        res_o.status   = ST_SAT;
      end else begin
        res_o.solution = 32'(-quo_q[31:0]);
      end
    end
  end
endmodule

[rtl/tfs_ctrl.sv]
module tfs_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          solve_i,
  input  logic [4:0]    size_i,
  output tfs_pkg::ctl_t ctl_o,
  output logic          last_o,
  output logic          busy_o,
  output logic          valid_o
);
  import tfs_pkg::*;

  state_e          state_q, state_d;
  logic [IdxW-1:0] i_q, i_d, j_q, j_d, n1_q, n1_d;
  logic [6:0]      cnt_q, cnt_d;
  logic            mac_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      i_q <= '0; j_q <= '0; n1_q <= '0; cnt_q <= '0; mac_q <= 1'b0;
    end else begin
      state_q <= state_d;
      i_q <= i_d; j_q <= j_d; n1_q <= n1_d; cnt_q <= cnt_d;
      mac_q <= (state_q == S_MAC) && (j_q != i_q);
    end
  end

  always_comb begin
    state_d = state_q;
    i_d = i_q; j_d = j_q; n1_d = n1_q; cnt_d = cnt_q;
    ctl_o = '0;
    ctl_o.i = i_q;
    ctl_o.j = j_q;
    ctl_o.mac = mac_q;
    valid_o = 1'b0;
    busy_o = (state_q != S_IDLE);
    unique case (state_q)
      S_IDLE: if (solve_i) begin
        if (size_i == 5'd0)           n1_d = '0;
        else if (size_i > 5'(MaxSize)) n1_d = IdxW'(MaxSize - 1);
        else                          n1_d = IdxW'(size_i - 5'd1);
        i_d = '0; j_d = '0;
        state_d = S_RD;
      end
      S_RD: begin
        ctl_o.row_clr = 1'b1;
        state_d = S_MAC;
      end
      // issue reads j = 0..i; products land in the next cycle
      S_MAC: begin
        if (j_q == i_q) state_d = S_DIVINIT;
        else j_d = j_q + 1'b1;
      end
      S_DIVINIT: begin
        ctl_o.div_init = 1'b1;
        cnt_d = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        ctl_o.div_step = 1'b1;
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'd63) state_d = S_EMIT;
      end
      S_EMIT: begin
        ctl_o.emit = 1'b1;
        valid_o = 1'b1;
        if (i_q == n1_q) state_d = S_IDLE;
        else begin
          i_d = i_q + 1'b1; j_d = '0;
          state_d = S_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
    last_o = (i_q == n1_q);
  end
endmodule

[dv/tfs_solution_checker.sv]
`timescale 1ns / 1ps

module tfs_solution_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  logic          busy,
  input  tfs_pkg::in_t  in_i,
  input  logic          cfg_we_i,
  input  logic [4:0]    cfg_data_i,
  input  logic          strobe,
  input  tfs_pkg::out_t out_o,
  output int            fail_count,
  output int            pending_count
);
  import tfs_pkg::*;

  logic signed [31:0] coef_mem [MaxSize][MaxSize];
  logic signed [31:0] rhs_mem [MaxSize];
  logic signed [31:0] x_mem [MaxSize];
  logic [4:0]         size_reg;
  out_t               solution_q [$];

  assign pending_count = solution_q.size();

  task automatic solve_system();
    int unsigned n;
    logic signed [63:0] acc, num, prod;
    logic [63:0] nmag, dmag, q;
    logic signed [31:0] diag, x;
    status_e st;
    logic neg;
    out_t r;
    n = (size_reg == 0) ? 1 : (size_reg > MaxSize ? MaxSize : size_reg);
    for (int i = 0; i < n; i++) begin
      acc = 0;
      for (int j = 0; j < i; j++) begin
        prod = 64'(x_mem[j]) * 64'(coef_mem[i][j]);
        acc  = acc + prod;
      end
      num  = 64'(rhs_mem[i]) - acc;
      diag = coef_mem[i][i];
      st   = ST_OK;
      if (diag == 0) begin
        x  = 0;
        st = ST_ZERO;
      end else begin
        nmag = num[63] ? -num : num;
        dmag = diag[31] ? -64'(diag) : 64'(diag);
        q    = nmag / dmag;
        neg  = num[63] != diag[31];
        if (!neg) begin
          if (q > 64'h7FFF_FFFF) begin
            q  = 64'h7FFF_FFFF;
            st = ST_SAT;
          end
          x = q[31:0];
        end else begin
          if (q > 64'h8000_0000) begin
            q  = 64'h8000_0000;
            st = ST_SAT;
          end
          x = -q[31:0];
        end
      end
      x_mem[i]        = x;
      r.unknown_index = i[3:0];
      r.solution      = x;
      r.status        = st;
      r.last          = (i + 1 == n);
      solution_queue_push(r);
    end
  endtask

  function automatic void solution_queue_push(out_t r);
    solution_q.push_back(r);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      size_reg   <= 5'd1;
      fail_count <= 0;
      for (int k = 0; k < MaxSize; k++) x_mem[k] = 0;
      solution_q.delete();
    end else begin
      // check results before predicting; a solve never finishes in its accept cycle
      if (strobe) begin
        if (solution_q.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected result %p", out_o);
        end else begin
          want = solution_q.pop_front();
          if (out_o !== want) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10) $display("mismatch: expected %p, got %p", want, out_o);
          end
        end
      end
      if (cfg_we_i) size_reg <= cfg_data_i;
      if (start && !busy) begin
        case (cmd_e'(in_i.cmd))
          CMD_COEF:  if (in_i.col <= in_i.row) coef_mem[in_i.row][in_i.col] = in_i.value;
          CMD_RHS:   rhs_mem[in_i.row] = in_i.value;
          CMD_SOLVE: solve_system();
          default: ;
        endcase
      end
    end
  end
endmodule

[dv/triangular_forward_substitution_unit_tb.sv]
`timescale 1ns / 1ps

module triangular_forward_substitution_unit_tb;
  import tfs_pkg::*;

  localparam int IdleLimit = 4000;

  logic          clk_i = 0;
  logic          rst_ni = 0;
  logic          start = 0;
  logic          busy;
  in_t           in_i = '0;
  logic          cfg_we_i = 0;
  logic [4:0]    cfg_data_i = 5'd1;
  logic          strobe;
  out_t          out_o;
  int            fail_count, pending_count;
  int            idle_cycles = 0;

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  triangular_forward_substitution_unit DUT (.*);
  tfs_solution_checker u_checker (.*);

  // watchdog: count cycles with no beat accepted and no result
  always @(posedge clk_i) begin
    if ((start && !busy) || strobe) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return $signed(32'($urandom_range(0, 6))) - 3;
      3: return $urandom();
      default: return $signed(32'($urandom_range(0, 200))) - 100;
    endcase
  endfunction

  task automatic send_beat(cmd_e c, int r, int cl, logic signed [31:0] v);
    repeat ($urandom_range(0, 7)) @(posedge clk_i);
    start     <= 1'b1;
    in_i.cmd  <= c;
    in_i.row  <= r[3:0];
    in_i.col  <= cl[3:0];
    in_i.value <= v;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    start <= 1'b0;
  endtask

  task automatic set_size(int n);
    // let the checker and busy settle after the last accepted beat
    @(posedge clk_i);
    while (pending_count != 0 || busy) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= n[4:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // fill the whole lower triangle and every right-hand side
  task automatic load_system(bit small_vals);
    for (int r = 0; r < MaxSize; r++) begin
      for (int c = 0; c <= r; c++)
        send_beat(CMD_COEF, r, c, small_vals ? $signed(32'($urandom_range(0, 8))) - 4
                                             : rand_value());
      send_beat(CMD_RHS, r, 0, rand_value());
    end
  endtask

  initial begin
    int sizes [6] = '{1, 16, 0, 31, 3, 17};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: extremes, every command, ignored writes
    send_beat(CMD_COEF, 0, 0, 32'sh8000_0000);
    send_beat(CMD_RHS, 0, 0, 32'sh7FFF_FFFF);
    send_beat(CMD_COEF, 0, 5, 32'sh1234);
    send_beat(CMD_NONE, 15, 15, 32'hFFFF_FFFF);
    send_beat(CMD_SOLVE, 0, 0, 0);
    send_beat(CMD_COEF, 0, 0, -1);
    send_beat(CMD_RHS, 0, 0, 32'sh8000_0000);
    send_beat(CMD_SOLVE, 15, 15, 32'hFFFF_FFFF);
    send_beat(CMD_COEF, 0, 0, 0);
    send_beat(CMD_SOLVE, 0, 0, 0);
    load_system(1'b1);
    foreach (sizes[k]) begin
      set_size(sizes[k]);
      send_beat(CMD_SOLVE, $urandom_range(0, 15), $urandom_range(0, 15), $urandom());
    end
    // random: rewrite entries, occasional solves
    for (int k = 0; k < 20; k++) begin
      int p;
      p = $urandom_range(0, 19);
      if (p == 0) begin
        set_size($urandom_range(0, 31));
        send_beat(CMD_SOLVE, 0, 0, $urandom());
      end else if (p < 3) send_beat(CMD_SOLVE, $urandom_range(0, 15), 0, $urandom());
      else if (p == 3) send_beat(CMD_NONE, $urandom_range(0, 15), $urandom_range(0, 15),
                                 $urandom());
      else if (p < 12) begin
        int r;
        r = $urandom_range(0, 15);
        // upper-triangle writes are ignored by the block
        send_beat(CMD_COEF, r, $urandom_range(0, 15), rand_value());
      end else send_beat(CMD_RHS, $urandom_range(0, 15), $urandom_range(0, 15), rand_value());
    end
    set_size(16);
    send_beat(CMD_SOLVE, 0, 0, 0);
    @(posedge clk_i);
    while (pending_count != 0 || busy) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
